[rtl/ste_pkg.sv]
// Shared types and constants for the scene table engine.
`default_nettype none
package ste_pkg;
   typedef enum logic [2:0] {
      OP_ADD = 3'd0, OP_VIEW = 3'd1, OP_REMOVE = 3'd2, OP_REMOVE_ALL = 3'd3,
      OP_STORE = 3'd4, OP_RECALL = 3'd5, OP_MEMBER = 3'd6, OP_NONE = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_INVALID = 2'd1, ST_NOT_FOUND = 2'd2, ST_NO_SPACE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_ACT, S_RD, S_OUT, S_LIST
   } state_type;

   localparam logic [15:0] CL_ON_OFF = 16'h0006;
   localparam logic [15:0] CL_LEVEL  = 16'h0008;
   localparam logic [3:0]  EXT_FULL  = 4'd8;

   // Controller to datapath commands.
   typedef struct packed {
      logic capture;  // latch the request
      logic clr_scan; // restart the scan index
      logic scan;     // examine one entry
      logic act;      // perform the write or clear for the command
      logic rd;       // issue a read of the found entry
      logic emit;     // drive a single result
      logic lst_rst;  // restart the listing index
      logic lst_step; // emit one listed scene and advance
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic   scan_done;
      logic   lst_more;
      logic   has_list;
      op_type op;
   } stat_type;
endpackage
`default_nettype wire

[rtl/ste_ctrl.sv]
// Command sequencer for the scene table engine.
`default_nettype none
module ste_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  ste_pkg::stat_type      stat,
   output ste_pkg::cmd_type       cmd
);
   import ste_pkg::*;
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: if (start) begin
            cmd.capture  = 1'b1;
            cmd.clr_scan = 1'b1;
            state_in     = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) state_in = S_ACT;
         end
         S_ACT: begin
            if (stat.op == OP_NONE) state_in = S_IDLE;
            else if (stat.op == OP_MEMBER) begin
               cmd.lst_rst = 1'b1;
               if (stat.has_list) state_in = S_LIST;
               else state_in = S_OUT;
            end else if (stat.op == OP_VIEW || stat.op == OP_RECALL) begin
               cmd.rd   = 1'b1;
               state_in = S_RD;
            end else begin
               cmd.act  = 1'b1;
               state_in = S_OUT;
            end
         end
         S_RD: state_in = S_OUT;
         S_OUT: begin
            cmd.emit = 1'b1;
            state_in = S_IDLE;
         end
         S_LIST: begin
            cmd.lst_step = 1'b1;
            if (!stat.lst_more) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

[rtl/ste_data.sv]
// Scene table storage, search and result formatting.
`default_nettype none
module ste_data #(
   parameter int ENTRIES = 16,
   parameter int IW      = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  ste_pkg::cmd_type         cmd,
   output ste_pkg::stat_type        stat,
   input  wire logic [2:0]          req_op,
   input  wire logic [7:0]          req_endpoint,
   input  wire logic [15:0]         req_group_id,
   input  wire logic [7:0]          req_scene_id,
   input  wire logic                req_group_known,
   input  wire logic [15:0]         req_trans_time,
   input  wire logic [7:0]          req_ext_len,
   input  wire logic [63:0]         req_ext_data,
   input  wire logic                req_unicast,
   input  wire logic [7:0]          req_on_off_now,
   input  wire logic [7:0]          req_level_now,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_status,
   output logic                     rsp_respond,
   output logic [15:0]              rsp_resp_group,
   output logic [7:0]               rsp_resp_scene,
   output logic [15:0]              rsp_resp_trans_time,
   output logic [3:0]               rsp_resp_ext_len,
   output logic [63:0]              rsp_resp_ext_data,
   output logic [4:0]               rsp_capacity,
   output logic [4:0]               rsp_list_count,
   output logic [1:0]               rsp_apply_mask,
   output logic [15:0]              rsp_recall_values,
   output logic                     rsp_last
);
   import ste_pkg::*;
   localparam int CW = $clog2(ENTRIES + 1);

   op_type      op_ff;
   logic [7:0]  ep_ff, sc_ff, on_ff, lv_ff;
   logic [15:0] grp_ff, tt_ff;
   logic        known_ff, uni_ff;
   logic [3:0]  elen_ff;
   logic [63:0] edata_ff;

   logic [ENTRIES-1:0] used_ff;
   logic [7:0]         ent_ep_ff [ENTRIES];
   logic [15:0]        ent_grp_ff [ENTRIES];
   logic [7:0]         ent_sc_ff [ENTRIES];
   logic [ENTRIES-1:0] grp_hit_ff; // endpoint and group match, entry in use

   logic [CW-1:0] idx_ff;
   logic          hit_ff, free_ok_ff;
   logic [IW-1:0] hit_idx_ff, free_idx_ff;
   logic [CW-1:0] used_cnt_ff, list_cnt_ff;
   logic [CW-1:0] lidx_ff;

   logic [IW-1:0] cur;
   assign cur = idx_ff[IW-1:0];
   logic ok;
   assign ok = (grp_ff == 16'h0000) || known_ff;

   // Payload stores that are only read at one computed address.
   logic        pay_we;
   logic [IW-1:0] pay_ra;
   logic [83:0] pay_wd, pay_rd;

   logic [IW-1:0] slot;
   logic          slot_ok;
   assign slot_ok = hit_ff || free_ok_ff;
   assign slot = hit_ff ? hit_idx_ff : free_idx_ff;

   logic [63:0] keep_mask;
   always_comb begin
      for (int b = 0; b < 8; b++)
         keep_mask[b*8 +: 8] = (4'(b) < elen_ff) ? 8'hFF : 8'h00;
   end

   logic [63:0] store_data;
   assign store_data = {lv_ff, 8'h01, CL_LEVEL[15:8], CL_LEVEL[7:0],
                        on_ff, 8'h01, CL_ON_OFF[15:8], CL_ON_OFF[7:0]};

   // Store needs the existing transition time; a read-modify-write is avoided
   // by writing the keep path only on the store of a new entry.
   logic store_wr;
   always_comb begin
      pay_we = 1'b0; pay_wd = '0; store_wr = 1'b0;
      pay_ra = hit_idx_ff;
      if (cmd.act && ok && slot_ok) begin
         if (op_ff == OP_ADD) begin
            pay_we = 1'b1;
            pay_wd = {tt_ff, elen_ff, edata_ff & keep_mask};
         end else if (op_ff == OP_STORE) begin
            store_wr = 1'b1;
         end
      end
   end

   // Transition time kept apart so that store can leave it alone.
   logic [67:0] ext_rd;
   logic        ext_we;
   logic [67:0] ext_wd;
   assign ext_we = pay_we || store_wr;
   assign ext_wd = store_wr ? {EXT_FULL, store_data} : pay_wd[67:0];
   ste_ram #(.WIDTH(68), .DEPTH(ENTRIES)) u_ext (
      .clock(clock), .we(ext_we), .waddr(slot), .wdata(ext_wd),
      .raddr(pay_ra), .rdata(ext_rd));

   logic        tt_we;
   logic [15:0] tt_wd, tt_rd;
   assign tt_we = pay_we || (store_wr && !hit_ff);
   assign tt_wd = pay_we ? pay_wd[83:68] : 16'h0000;
   ste_ram #(.WIDTH(16), .DEPTH(ENTRIES)) u_tt (
      .clock(clock), .we(tt_we), .waddr(slot), .wdata(tt_wd),
      .raddr(pay_ra), .rdata(tt_rd));
   assign pay_rd = {tt_rd, ext_rd};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= op_type'(req_op);
         ep_ff <= req_endpoint; grp_ff <= req_group_id; sc_ff <= req_scene_id;
         known_ff <= req_group_known; tt_ff <= req_trans_time;
         elen_ff <= (req_ext_len > 8'd8) ? EXT_FULL : req_ext_len[3:0];
         edata_ff <= req_ext_data; uni_ff <= req_unicast;
         on_ff <= req_on_off_now; lv_ff <= req_level_now;
      end
   end

   logic ehit, gmatch;
   assign gmatch = used_ff[cur] && ent_ep_ff[cur] == ep_ff && ent_grp_ff[cur] == grp_ff;
   assign ehit   = gmatch && ent_sc_ff[cur] == sc_ff;

   always_ff @(posedge clock) begin
      if (cmd.clr_scan) begin
         idx_ff <= '0; hit_ff <= 1'b0; free_ok_ff <= 1'b0;
         used_cnt_ff <= '0; list_cnt_ff <= '0;
         hit_idx_ff <= '0; free_idx_ff <= '0;
      end else if (cmd.scan) begin
         idx_ff <= idx_ff + 1'b1;
         grp_hit_ff[cur] <= gmatch;
         if (ehit && !hit_ff) begin hit_ff <= 1'b1; hit_idx_ff <= cur; end
         if (!used_ff[cur] && !free_ok_ff) begin free_ok_ff <= 1'b1; free_idx_ff <= cur; end
         if (used_ff[cur]) used_cnt_ff <= used_cnt_ff + 1'b1;
         if (gmatch && ok) list_cnt_ff <= list_cnt_ff + 1'b1;
      end
   end
   assign stat.scan_done = cmd.scan && (idx_ff == CW'(ENTRIES - 1));
   assign stat.op = op_ff;
   assign stat.has_list = ok && (list_cnt_ff != '0);

   // Table keys and use bits.
   always_ff @(posedge clock) begin
      if (reset) used_ff <= '0;
      else if (cmd.act && ok) begin
         unique case (op_ff)
            OP_ADD, OP_STORE: if (slot_ok) used_ff[slot] <= 1'b1;
            OP_REMOVE_ALL: used_ff <= used_ff & ~grp_hit_ff;
            default: ;
         endcase
      end
      if (!reset && cmd.act && op_ff == OP_REMOVE && hit_ff) used_ff[hit_idx_ff] <= 1'b0;
   end
   always_ff @(posedge clock) begin
      if (cmd.act && ok && slot_ok && (op_ff == OP_ADD || op_ff == OP_STORE)) begin
         ent_ep_ff[slot] <= ep_ff; ent_grp_ff[slot] <= grp_ff; ent_sc_ff[slot] <= sc_ff;
      end
   end

   // Listing walk over matching entries.
   logic [CW-1:0] lnext;
   logic          lfound;
   logic [CW-1:0] emitted_ff;
   always_comb begin
      lnext = CW'(ENTRIES); lfound = 1'b0;
      for (int i = 0; i < ENTRIES; i++)
         if (!lfound && CW'(i) >= lidx_ff && grp_hit_ff[i]) begin
            lfound = 1'b1; lnext = CW'(i);
         end
   end
   always_ff @(posedge clock) begin
      if (cmd.lst_rst) begin lidx_ff <= '0; emitted_ff <= '0; end
      else if (cmd.lst_step) begin
         lidx_ff <= lnext + 1'b1; emitted_ff <= emitted_ff + 1'b1;
      end
   end
   assign stat.lst_more = (emitted_ff + 1'b1) != list_cnt_ff;

   // Recall parse: two records at most.
   logic [1:0]  mask;
   logic [15:0] vals;
   always_comb begin
      logic stop;
      logic [15:0] cl;
      mask = '0; vals = '0; stop = 1'b0;
      for (int r = 0; r < 2; r++) begin
         cl = pay_rd[r*32 +: 16];
         if (!stop && (4'(r*4 + 4) <= pay_rd[67:64])) begin
            if (cl == CL_ON_OFF) begin mask[0] = 1'b1; vals[7:0] = pay_rd[r*32+24 +: 8]; end
            else if (cl == CL_LEVEL) begin mask[1] = 1'b1; vals[15:8] = pay_rd[r*32+24 +: 8]; end
            else stop = 1'b1;
         end else stop = 1'b1;
      end
   end

   logic [4:0] cap;
   assign cap = 5'(CW'(ENTRIES) - used_cnt_ff);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else rsp_valid <= cmd.emit || cmd.lst_step;
      rsp_status <= ST_OK; rsp_respond <= 1'b0; rsp_resp_group <= grp_ff;
      rsp_resp_scene <= sc_ff; rsp_resp_trans_time <= '0; rsp_resp_ext_len <= '0;
      rsp_resp_ext_data <= '0; rsp_capacity <= '0; rsp_list_count <= '0;
      rsp_apply_mask <= '0; rsp_recall_values <= '0; rsp_last <= 1'b1;
      unique case (op_ff)
         OP_ADD: begin
            rsp_respond <= 1'b1;
            rsp_status <= !ok ? ST_INVALID : (slot_ok ? ST_OK : ST_NO_SPACE);
         end
         OP_VIEW: begin
            rsp_respond <= 1'b1;
            if (hit_ff) begin
               rsp_resp_trans_time <= pay_rd[83:68];
               rsp_resp_ext_len <= pay_rd[67:64];
               rsp_resp_ext_data <= pay_rd[63:0];
            end else rsp_status <= ok ? ST_NOT_FOUND : ST_INVALID;
         end
         OP_REMOVE: begin
            rsp_respond <= uni_ff;
            if (!hit_ff) rsp_status <= known_ff ? ST_NOT_FOUND : ST_INVALID;
         end
         OP_REMOVE_ALL: begin
            rsp_respond <= uni_ff; rsp_resp_scene <= '0;
            if (!ok) rsp_status <= ST_INVALID;
         end
         OP_STORE: begin
            rsp_respond <= uni_ff;
            rsp_status <= !ok ? ST_INVALID : (slot_ok ? ST_OK : ST_NO_SPACE);
         end
         OP_RECALL: begin
            if (hit_ff) begin rsp_apply_mask <= mask; rsp_recall_values <= vals; end
            else rsp_status <= ST_NOT_FOUND;
         end
         OP_MEMBER: begin
            rsp_capacity <= cap;
            if (!ok) begin
               rsp_status <= ST_INVALID; rsp_respond <= 1'b1; rsp_resp_scene <= '0;
            end else if (cmd.lst_step) begin
               rsp_respond <= 1'b1;
               rsp_resp_scene <= ent_sc_ff[lnext[IW-1:0]];
               rsp_list_count <= 5'(list_cnt_ff);
               rsp_last <= !stat.lst_more;
            end else begin
               rsp_respond <= uni_ff; rsp_resp_scene <= '0;
            end
         end
         default: ;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.act |-> !(cmd.scan || cmd.emit)) else $error("act overlaps scan or emit");
   assert property (@(posedge clock) disable iff (reset)
      cmd.lst_step |-> lfound) else $error("listing ran past the last match");
   assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> !rsp_valid) else $error("result during capture");
endmodule
`default_nettype wire

[rtl/ste_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ste_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]              rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

[rtl/scene_table_engine_unit.sv]
// Top level of the scene table engine: controller and table datapath.
// A command passes through scan, action and result states; a no-op gives no result;
// view and recall also pass through a read state for the payload RAM read.
// Membership emits one result per cycle after the scan, one per matching scene, or one result if none.
// A new command is accepted only while idle; busy stays high until the last result.
// Synchronous reset clears the use bits and the controller; the receiver cannot stall.
`default_nettype none
module scene_table_engine_unit #(
   parameter int TABLE_ENTRIES = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire logic [2:0]   req_op,
   input  wire logic [7:0]   req_endpoint,
   input  wire logic [15:0]  req_group_id,
   input  wire logic [7:0]   req_scene_id,
   input  wire logic         req_group_known,
   input  wire logic [15:0]  req_trans_time,
   input  wire logic [7:0]   req_ext_len,
   input  wire logic [63:0]  req_ext_data,
   input  wire logic         req_unicast,
   input  wire logic [7:0]   req_on_off_now,
   input  wire logic [7:0]   req_level_now,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output logic              rsp_respond,
   output logic [15:0]       rsp_resp_group,
   output logic [7:0]        rsp_resp_scene,
   output logic [15:0]       rsp_resp_trans_time,
   output logic [3:0]        rsp_resp_ext_len,
   output logic [63:0]       rsp_resp_ext_data,
   output logic [4:0]        rsp_capacity,
   output logic [4:0]        rsp_list_count,
   output logic [1:0]        rsp_apply_mask,
   output logic [15:0]       rsp_recall_values,
   output logic              rsp_last
);
   import ste_pkg::*;

   // The controller only sees status; the datapath holds all table state.
   cmd_type  cmd;
   stat_type stat;

   ste_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .stat(stat), .cmd(cmd));

   // A transfer is accepted when start is high while busy is low.
   ste_data #(.ENTRIES(TABLE_ENTRIES), .IW($clog2(TABLE_ENTRIES) > 0 ?
              $clog2(TABLE_ENTRIES) : 1)) u_data (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_op(req_op), .req_endpoint(req_endpoint), .req_group_id(req_group_id),
      .req_scene_id(req_scene_id), .req_group_known(req_group_known),
      .req_trans_time(req_trans_time), .req_ext_len(req_ext_len),
      .req_ext_data(req_ext_data), .req_unicast(req_unicast),
      .req_on_off_now(req_on_off_now), .req_level_now(req_level_now),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_respond(rsp_respond),
      .rsp_resp_group(rsp_resp_group), .rsp_resp_scene(rsp_resp_scene),
      .rsp_resp_trans_time(rsp_resp_trans_time), .rsp_resp_ext_len(rsp_resp_ext_len),
      .rsp_resp_ext_data(rsp_resp_ext_data), .rsp_capacity(rsp_capacity),
      .rsp_list_count(rsp_list_count), .rsp_apply_mask(rsp_apply_mask),
      .rsp_recall_values(rsp_recall_values), .rsp_last(rsp_last));
endmodule
`default_nettype wire
